// ----- sv/single_source_shortest_paths_defines.svh -----
// Assertion macros for the shortest path checker.
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define SSSP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define SSSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/sssp_pkg.sv -----
// Package with sizes, codes and types of the shortest path block.
package sssp_pkg;

   // Sizing of the stores
   localparam int MAX_NODES   = 32;
   localparam int MAX_EDGES   = 64;
   localparam int WEIGHT_BITS = 10;

   // Fixed field widths
   localparam int NODE_W   = 6;
   localparam int WEIGHT_W = 10;
   localparam int DIST_W   = 16;

   // Derived widths
   localparam int NA_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int CMP_W  = (NODE_W > CNT_W) ? NODE_W : CNT_W;
   localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EC_W   = $clog2(MAX_EDGES + 1);
   localparam int EDGE_W = 2 * NODE_W + WEIGHT_BITS;

   // Distance codes: 17-bit form, top bit set only for infinite
   localparam logic [DIST_W:0]   DIST_INF = {(DIST_W + 1){1'b1}};
   localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

   // Request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_RUN  = 1'b1;

   // Node count after reset
   localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(32);

   // Commands to the distance table
   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [NA_W-1:0]   rd_addr;
      logic              wr_en;
      logic [NA_W-1:0]   wr_addr;
      logic [DIST_W-1:0] wr_data;
   } dist_cmd_type;

   // Map the programmed node count onto 1..MAX_NODES
   function automatic logic [CNT_W-1:0] eff_nodes(input logic [NODE_W-1:0] v);
      logic [CNT_W-1:0] n;
      if (v == '0) begin
         n = CNT_W'(1);
      end else if (int'(v) > MAX_NODES) begin
         n = CNT_W'(MAX_NODES);
      end else begin
         n = CNT_W'(v);
      end
      return n;
   endfunction

endpackage

// ----- sv/sssp_dist.sv -----
// Distance table: one memory of node distances with per-entry valid bits.
module sssp_dist (
   input  logic                      clock,
   input  logic                      reset,
   input  sssp_pkg::dist_cmd_type    cmd,
   output logic [sssp_pkg::DIST_W:0] rd_dist
);
   import sssp_pkg::*;

   logic [DIST_W-1:0]    dist_mem [MAX_NODES];
   logic [MAX_NODES-1:0] valid_ff;
   logic [MAX_NODES-1:0] valid_in;
   logic [DIST_W-1:0]    rd_data_ff;
   logic                 rd_valid_ff;

   // Drop all entries on clear, mark the written entry valid
   always_comb begin
      valid_in = cmd.clear ? '0 : valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.rd_addr];
         end
      end
   end

   // Write and registered read of the table
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         dist_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= dist_mem[cmd.rd_addr];
      end
   end

   // An entry not written in this run reads as infinite
   assign rd_dist = rd_valid_ff ? {1'b0, rd_data_ff} : DIST_INF;

endmodule

// ----- sv/single_source_shortest_paths.sv -----
// Top level of the single-source shortest path engine.
// A load item (req_type 0) appends one directed edge to a 64-entry edge store;
// once the store is full further edges are dropped and every result of the
// next run shows edges_dropped. A run item (req_type 1) finds the shortest distance
// from node 1 to nodes 1..n (n from the value written on csr_wr_data, 0 read as 1 and
// values above 32 read as 32) and then gives one result per node in order, last on
// node n; afterwards the edge store is empty.
// The search is sequenced over one distance table port and one add and compare unit:
// a setup step, then per round a scan of nodes 1..n to pick the closest open node,
// a commit step, and a pass that reads each stored edge and, for an edge that leaves
// the picked node and lands on a node in 1..n, reads and relaxes its distance.
// There are as many rounds as reachable nodes plus one final scan. Each result is
// then read and loaded, waiting while the result side holds the one before. The
// block takes no new item from the start of a run until its last result is loaded.
module single_source_shortest_paths (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration
   input  logic                            csr_wr_en,
   input  logic [sssp_pkg::NODE_W-1:0]     csr_wr_data,
   // Requests
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [sssp_pkg::NODE_W-1:0]     req_edge_src,
   input  logic [sssp_pkg::NODE_W-1:0]     req_edge_dst,
   input  logic [sssp_pkg::WEIGHT_W-1:0]   req_edge_weight,
   // Results
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sssp_pkg::NODE_W-1:0]     rsp_node_index,
   output logic [sssp_pkg::DIST_W-1:0]     rsp_distance,
   output logic                            rsp_reachable,
   output logic                            rsp_edges_dropped,
   output logic                            rsp_last
);
   import sssp_pkg::*;

   // Sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INIT     = 4'd1;
   localparam logic [3:0] S_SCAN_RD  = 4'd2;
   localparam logic [3:0] S_SCAN_CMP = 4'd3;
   localparam logic [3:0] S_SEL      = 4'd4;
   localparam logic [3:0] S_EDGE_RD  = 4'd5;
   localparam logic [3:0] S_EDGE_DR  = 4'd6;
   localparam logic [3:0] S_EDGE_UP  = 4'd7;
   localparam logic [3:0] S_OUT_RD   = 4'd8;
   localparam logic [3:0] S_OUT_LD   = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic [NODE_W-1:0]    node_count_ff, node_count_in;
   logic [EC_W-1:0]      edge_count_ff, edge_count_in;
   logic                 overflow_ff, overflow_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     best_ff, best_in;
   logic [DIST_W:0]      bestd_ff, bestd_in;
   logic [CNT_W-1:0]     sel_ff, sel_in;
   logic [DIST_W-1:0]    base_ff, base_in;
   logic [EC_W-1:0]      e_ff, e_in;
   logic [MAX_NODES-1:0] done_ff, done_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]    rsp_node_ff, rsp_node_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                 rsp_reach_ff, rsp_reach_in;
   logic                 rsp_drop_ff, rsp_drop_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [EDGE_W-1:0]    edge_mem [MAX_EDGES];
   logic [EDGE_W-1:0]    edge_q_ff;
   logic                 edge_we;
   logic                 edge_re;
   logic [EDGE_W-1:0]    edge_wdata;

   dist_cmd_type         dcmd;
   logic [DIST_W:0]      rd_dist;

   logic [NA_W-1:0]        idx_addr;
   logic [NA_W-1:0]        best_addr;
   logic [NODE_W-1:0]      e_src;
   logic [NODE_W-1:0]      e_dst;
   logic [WEIGHT_BITS-1:0] e_wt;
   logic [NA_W-1:0]        dst_addr;
   logic                   edge_hit;
   logic [EC_W-1:0]        e_next;
   logic                   e_last;
   logic [DIST_W:0]        sum;
   logic [DIST_W:0]        nd;
   logic [DIST_W:0]        cmp_a;
   logic [DIST_W:0]        cmp_b;
   logic                   cmp_lt;

   sssp_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (dcmd),
      .rd_dist (rd_dist)
   );

   // Address and edge decode
   assign idx_addr   = NA_W'(idx_ff - CNT_W'(1));
   assign best_addr  = NA_W'(best_ff - CNT_W'(1));
   assign e_src      = edge_q_ff[EDGE_W-1 -: NODE_W];
   assign e_dst      = edge_q_ff[WEIGHT_BITS +: NODE_W];
   assign e_wt       = edge_q_ff[WEIGHT_BITS-1:0];
   assign dst_addr   = NA_W'(e_dst - NODE_W'(1));
   assign edge_hit   = (CMP_W'(e_src) == CMP_W'(sel_ff)) && (e_dst != '0) &&
                       (CMP_W'(e_dst) <= CMP_W'(n_ff));
   assign e_next     = e_ff + EC_W'(1);
   assign e_last     = (e_next == edge_count_ff);
   assign edge_wdata = {req_edge_src, req_edge_dst, WEIGHT_BITS'(req_edge_weight)};

   // Shared unit: saturating add and one compare
   assign sum    = {1'b0, base_ff} + (DIST_W + 1)'(e_wt);
   assign nd     = sum[DIST_W] ? {1'b0, DIST_SAT} : sum;
   assign cmp_lt = cmp_a < cmp_b;

   assign req_ready = (state_ff == S_IDLE);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      edge_count_in = edge_count_ff;
      overflow_in   = overflow_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      bestd_in      = bestd_ff;
      sel_in        = sel_ff;
      base_in       = base_ff;
      e_in          = e_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_reach_in  = rsp_reach_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_last_in   = rsp_last_ff;
      edge_we       = 1'b0;
      edge_re       = 1'b0;
      dcmd          = '0;
      cmp_a         = rd_dist;
      cmp_b         = bestd_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         node_count_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_LOAD) begin
                  if (edge_count_ff < EC_W'(MAX_EDGES)) begin
                     edge_we       = 1'b1;
                     edge_count_in = edge_count_ff + EC_W'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  n_in     = eff_nodes(node_count_ff);
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            // Start from node 1 at distance zero, all else infinite
            dcmd.clear   = 1'b1;
            dcmd.wr_en   = 1'b1;
            dcmd.wr_addr = '0;
            dcmd.wr_data = '0;
            done_in      = '0;
            idx_in       = CNT_W'(1);
            best_in      = '0;
            bestd_in     = DIST_INF;
            state_in     = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            dcmd.rd_en   = 1'b1;
            dcmd.rd_addr = idx_addr;
            state_in     = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            // Keep the lowest-numbered open node with the smallest distance
            if (!done_ff[idx_addr] && cmp_lt) begin
               best_in  = idx_ff;
               bestd_in = rd_dist;
            end
            if (idx_ff == n_ff) begin
               state_in = S_SEL;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_SEL: begin
            idx_in = CNT_W'(1);
            if (best_ff == '0) begin
               state_in = S_OUT_RD;
            end else begin
               done_in[best_addr] = 1'b1;
               sel_in   = best_ff;
               base_in  = bestd_ff[DIST_W-1:0];
               best_in  = '0;
               bestd_in = DIST_INF;
               e_in     = '0;
               state_in = (edge_count_ff == '0) ? S_SCAN_RD : S_EDGE_RD;
            end
         end
         S_EDGE_RD: begin
            edge_re  = 1'b1;
            state_in = S_EDGE_DR;
         end
         S_EDGE_DR: begin
            if (edge_hit) begin
               dcmd.rd_en   = 1'b1;
               dcmd.rd_addr = dst_addr;
               state_in     = S_EDGE_UP;
            end else if (e_last) begin
               state_in = S_SCAN_RD;
            end else begin
               e_in     = e_next;
               state_in = S_EDGE_RD;
            end
         end
         S_EDGE_UP: begin
            // Relax the edge when the new path is shorter
            cmp_a = nd;
            cmp_b = rd_dist;
            if (cmp_lt) begin
               dcmd.wr_en   = 1'b1;
               dcmd.wr_addr = dst_addr;
               dcmd.wr_data = nd[DIST_W-1:0];
            end
            if (e_last) begin
               state_in = S_SCAN_RD;
            end else begin
               e_in     = e_next;
               state_in = S_EDGE_RD;
            end
         end
         S_OUT_RD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dcmd.rd_en   = 1'b1;
               dcmd.rd_addr = idx_addr;
               state_in     = S_OUT_LD;
            end
         end
         S_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = NODE_W'(idx_ff);
            rsp_reach_in = !rd_dist[DIST_W];
            rsp_dist_in  = rd_dist[DIST_W] ? '0 : rd_dist[DIST_W-1:0];
            rsp_drop_in  = overflow_ff;
            rsp_last_in  = (idx_ff == n_ff);
            if (idx_ff == n_ff) begin
               edge_count_in = '0;
               overflow_in   = 1'b0;
               state_in      = S_IDLE;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_OUT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         edge_count_ff <= '0;
         overflow_ff   <= 1'b0;
         done_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         edge_count_ff <= edge_count_in;
         overflow_ff   <= overflow_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      bestd_ff     <= bestd_in;
      sel_ff       <= sel_in;
      base_ff      <= base_in;
      e_ff         <= e_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Edge store: append on load, registered read during relaxation
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_count_ff[EA_W-1:0]] <= edge_wdata;
      end
      if (edge_re) begin
         edge_q_ff <= edge_mem[e_ff[EA_W-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_node_index    = rsp_node_ff;
   assign rsp_distance      = rsp_dist_ff;
   assign rsp_reachable     = rsp_reach_ff;
   assign rsp_edges_dropped = rsp_drop_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ----- sv/sssp_checker.sv -----
// Port-level checker for the shortest path engine, bound to the top level.
`include "single_source_shortest_paths_defines.svh"

module sssp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [sssp_pkg::NODE_W-1:0]     rsp_node_index,
   input logic [sssp_pkg::DIST_W-1:0]     rsp_distance,
   input logic                            rsp_reachable,
   input logic                            rsp_last
);

   // Hold a stalled result
   `SSSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_node_index) && $stable(rsp_distance) && $stable(rsp_last),
      "stalled result changed")

   // Unreachable nodes report zero distance
   `SSSP_ASSERT_IMP(a_unreach_zero, rsp_valid && !rsp_reachable, rsp_distance == '0,
      "unreachable node with nonzero distance")

   // The start node is always reachable at distance zero
   `SSSP_ASSERT_IMP(a_start_node, rsp_valid && rsp_node_index == sssp_pkg::NODE_W'(1),
      rsp_reachable && rsp_distance == '0, "start node not at distance zero")

   // A new run cannot produce a result right after the last one
   `SSSP_ASSERT_NEXT(a_last_gap, rsp_valid && rsp_ready && rsp_last, !rsp_valid,
      "result right after the last one")

endmodule

bind single_source_shortest_paths sssp_checker u_sssp_checker (.*);
